>>> rtl/fpc_pkg.sv
// Shared types, widths and helpers of the flow packet counter.
package fpc_pkg;

  localparam int unsigned SET_COUNT_DEF = 256;
  localparam int unsigned WAY_COUNT_DEF = 4;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned KEY_W   = 2 * ADDR_W;
  localparam int unsigned PORTS_W = 2 * PORT_W;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned HASH_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [PORTS_W-1:0] ports;
    logic [COUNT_W-1:0] count;
  } way_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_ONE;
  endfunction

endpackage

>>> rtl/flow_packet_counter.sv
// Flow packet counter top level: sequencer, set-associative flow table and totals.
//
// Input channel s_axis carries one packet four-tuple per transfer; output
// channel m_axis returns one result per packet, in order: the flow count
// after update, the new-flow and table-full flags, and the saturating
// packet and flow totals including this packet.
// One packet is in work at a time. From its transfer to its result a packet
// passes hash, row read, way compare and write-back; when SET_COUNT is not a
// power of two the set index comes from a reciprocal multiplication, and the
// remainder is registered after the quotient. The next packet is taken in the
// cycle after the result is registered. After reset a clearing pass writes
// every row of the table once, while s_axis_tready stays low.
// When the receiver stalls, the result holds in the output register; the
// next packet is still taken and worked up to its write-back, where it
// waits until the output register is free.
module flow_packet_counter #(
  parameter int unsigned SET_COUNT = fpc_pkg::SET_COUNT_DEF,
  parameter int unsigned WAY_COUNT = fpc_pkg::WAY_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // source_address, destination_address, source_port, destination_port
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // flow_count, total_packets, total_flows
  output logic [95:0]  m_axis_tdata,
  // new_flow, table_full
  output logic [1:0]   m_axis_tuser
);
  import fpc_pkg::*;

  localparam int unsigned SET_W = $clog2(SET_COUNT);
  localparam int unsigned WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned ROW_W = WAY_COUNT * $bits(way_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MATCH,
    ST_UPDATE
  } state_e;

  state_e state_q;

  logic [SET_W-1:0]   clr_q;
  logic [KEY_W-1:0]   key_q;
  logic [PORTS_W-1:0] ports_q;

  logic               hit_q, free_q;
  logic [WAY_W-1:0]   hit_way_q, free_way_q;

  logic               out_valid_q;
  logic [COUNT_W-1:0] flow_count_q;
  logic               new_flow_q;
  logic               table_full_q;
  logic [COUNT_W-1:0] packets_q;
  logic [COUNT_W-1:0] flows_q;

  logic               in_xfer;
  logic               out_free;
  logic               hash_done;
  logic [SET_W-1:0]   set_idx;

  way_t [WAY_COUNT-1:0] row_rd;
  way_t [WAY_COUNT-1:0] row_d;
  logic                 hit_c, free_c;
  logic [WAY_W-1:0]     hit_way_c, free_way_c;

  logic               rd_en;
  logic               wr_en;
  logic [SET_W-1:0]   wr_addr;
  logic [ROW_W-1:0]   wr_data;
  logic [ROW_W-1:0]   rd_data;
  logic [COUNT_W-1:0] count_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  fpc_set_index #(
    .SET_COUNT (SET_COUNT),
    .SET_W     (SET_W)
  ) u_set_index (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .src_addr_i (s_axis_tdata[31:0]),
    .dst_addr_i (s_axis_tdata[63:32]),
    .sport_i    (s_axis_tdata[79:64]),
    .dport_i    (s_axis_tdata[95:80]),
    .done_o     (hash_done),
    .index_o    (set_idx)
  );

  assign rd_en  = (state_q == ST_HASH) && hash_done;
  assign row_rd = rd_data;

  fpc_table_ram #(
    .WIDTH  (ROW_W),
    .DEPTH  (SET_COUNT),
    .ADDR_W (SET_W)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (set_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  fpc_way_match #(
    .WAY_COUNT (WAY_COUNT),
    .WAY_W     (WAY_W)
  ) u_way_match (
    .row_i      (row_rd),
    .key_i      (key_q),
    .ports_i    (ports_q),
    .hit_o      (hit_c),
    .hit_way_o  (hit_way_c),
    .free_o     (free_c),
    .free_way_o (free_way_c)
  );

  always_comb begin
    row_d   = row_rd;
    count_d = '0;
    if (hit_q) begin
      count_d                = sat_inc(row_rd[hit_way_q].count);
      row_d[hit_way_q].count = count_d;
    end else if (free_q) begin
      count_d           = COUNT_ONE;
      row_d[free_way_q] = '{valid: 1'b1, key: key_q, ports: ports_q, count: COUNT_ONE};
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = set_idx;
    wr_data = row_d;
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (state_q == ST_UPDATE && out_free) begin
      wr_en = hit_q || free_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      packets_q   <= '0;
      flows_q     <= '0;
    end else begin
      if (state_q == ST_UPDATE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == SET_W'(SET_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            state_q <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            packets_q <= sat_inc(packets_q);
            if (!hit_q && free_q) begin
              flows_q <= sat_inc(flows_q);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q   <= {s_axis_tdata[31:0], s_axis_tdata[63:32]};
      ports_q <= {s_axis_tdata[79:64], s_axis_tdata[95:80]};
    end
    if (state_q == ST_MATCH) begin
      hit_q      <= hit_c;
      hit_way_q  <= hit_way_c;
      free_q     <= free_c;
      free_way_q <= free_way_c;
    end
    if (state_q == ST_UPDATE && out_free) begin
      flow_count_q <= count_d;
      new_flow_q   <= !hit_q && free_q;
      table_full_q <= !hit_q && !free_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {flows_q, packets_q, flow_count_q};
  assign m_axis_tuser  = {table_full_q, new_flow_q};

endmodule

>>> rtl/fpc_set_index.sv
// Flow key hash: XOR fold of the four-tuple reduced to a set index.
module fpc_set_index #(
  parameter int unsigned SET_COUNT = fpc_pkg::SET_COUNT_DEF,
  parameter int unsigned SET_W     = $clog2(SET_COUNT)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fpc_pkg::ADDR_W-1:0] src_addr_i,
  input  logic [fpc_pkg::ADDR_W-1:0] dst_addr_i,
  input  logic [fpc_pkg::PORT_W-1:0] sport_i,
  input  logic [fpc_pkg::PORT_W-1:0] dport_i,
  output logic                      done_o,
  output logic [SET_W-1:0]          index_o
);
  import fpc_pkg::*;

  logic [HASH_W-1:0] fold;

  assign fold = src_addr_i[31:16] ^ src_addr_i[15:0] ^ dst_addr_i[31:16] ^
                dst_addr_i[15:0] ^ sport_i ^ dport_i;

  if ((SET_COUNT & (SET_COUNT - 1)) == 0) begin : g_mask
    logic             done_q;
    logic [SET_W-1:0] index_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        index_q <= fold[SET_W-1:0];
      end
    end

    assign done_o  = done_q;
    assign index_o = index_q;
  end else begin : g_reduce
    // quotient by reciprocal multiplication, remainder registered in the cycle after
    localparam int unsigned     PROD_W  = 2 * HASH_W + 1;
    localparam int unsigned     RECIP_W = HASH_W + 1;
    localparam int unsigned     SHIFT   = HASH_W + SET_W;
    localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(SET_COUNT) - 64'd1) / 64'(SET_COUNT);
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);
    localparam logic [HASH_W-1:0]  DIVISOR = HASH_W'(SET_COUNT);

    logic                stage_q;
    logic                done_q;
    logic [HASH_W-1:0]   fold_q;
    logic [HASH_W-1:0]   quot_q;
    logic [SET_W-1:0]    index_q;
    logic [PROD_W-1:0]   prod;
    logic [2*HASH_W-1:0] back;
    logic [HASH_W-1:0]   rem;

    assign prod = {{RECIP_W{1'b0}}, fold} * {{HASH_W{1'b0}}, RECIP};
    assign back = {{HASH_W{1'b0}}, quot_q} * {{HASH_W{1'b0}}, DIVISOR};
    assign rem  = fold_q - back[HASH_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= 1'b0;
        done_q  <= 1'b0;
      end else begin
        stage_q <= start_i;
        done_q  <= stage_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        fold_q <= fold;
        quot_q <= HASH_W'(prod >> SHIFT);
      end
      if (stage_q) begin
        index_q <= rem[SET_W-1:0];
      end
    end

    assign done_o  = done_q;
    assign index_o = index_q;
  end

endmodule

>>> rtl/fpc_table_ram.sv
// Flow table storage: one write port, one registered read port.
module fpc_table_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/fpc_way_match.sv
// Way compare: hit way and first free way of one table row.
module fpc_way_match #(
  parameter int unsigned WAY_COUNT = fpc_pkg::WAY_COUNT_DEF,
  parameter int unsigned WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1
) (
  input  fpc_pkg::way_t [WAY_COUNT-1:0] row_i,
  input  logic [fpc_pkg::KEY_W-1:0]     key_i,
  input  logic [fpc_pkg::PORTS_W-1:0]   ports_i,
  output logic                          hit_o,
  output logic [WAY_W-1:0]              hit_way_o,
  output logic                          free_o,
  output logic [WAY_W-1:0]              free_way_o
);
  import fpc_pkg::*;

  always_comb begin
    hit_o      = 1'b0;
    hit_way_o  = '0;
    free_o     = 1'b0;
    free_way_o = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (row_i[w].valid) begin
        if (row_i[w].key == key_i && row_i[w].ports == ports_i) begin
          hit_o     = 1'b1;
          hit_way_o = WAY_W'(w);
        end
      end else begin
        free_o     = 1'b1;
        free_way_o = WAY_W'(w);
      end
    end
  end

endmodule

>>> dv/flow_packet_counter_tb.sv
// Testbench for flow_packet_counter: directed and random packets checked against a flow table model.
`timescale 1ns / 100ps

module flow_packet_counter_tb;

  import fpc_pkg::*;

  localparam int unsigned SETS         = SET_COUNT_DEF;
  localparam int unsigned WAYS         = WAY_COUNT_DEF;
  localparam int unsigned RANDOM_PKTS  = 1030;
  localparam int unsigned CALM_PKTS    = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } packet_t;

  typedef struct {
    logic [COUNT_W-1:0] flow_count;
    logic               new_flow;
    logic               table_full;
    logic [COUNT_W-1:0] total_packets;
    logic [COUNT_W-1:0] total_flows;
  } flow_result_t;

  class flow_table_model;
    bit                 slot_used[SETS*WAYS];
    packet_t            slot_flow[SETS*WAYS];
    logic [COUNT_W-1:0] slot_count[SETS*WAYS];
    logic [COUNT_W-1:0] packets_seen;
    logic [COUNT_W-1:0] flows_inserted;
    flow_result_t       expected_results[$];
    int unsigned        mismatches;
    int unsigned        results_checked;
    int unsigned        hits;
    int unsigned        inserts;
    int unsigned        rejects;

    function new();
      packets_seen    = '0;
      flows_inserted  = '0;
      mismatches      = 0;
      results_checked = 0;
      hits            = 0;
      inserts         = 0;
      rejects         = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function logic [COUNT_W-1:0] sat_bump(logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_packet(packet_t p);
      logic [HASH_W-1:0] fold;
      int unsigned       base;
      int                hit_way;
      int                free_way;
      int                w;
      flow_result_t      r;
      fold = p.src_addr[31:16] ^ p.src_addr[15:0] ^ p.dst_addr[31:16] ^
             p.dst_addr[15:0] ^ p.sport ^ p.dport;
      base     = (fold % SETS) * WAYS;
      hit_way  = -1;
      free_way = -1;
      for (w = 0; w < WAYS; w++) begin
        if (slot_used[base+w]) begin
          if (hit_way < 0 && slot_flow[base+w] == p) hit_way = w;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      r.flow_count = '0;
      r.new_flow   = 1'b0;
      r.table_full = 1'b0;
      if (hit_way >= 0) begin
        slot_count[base+hit_way] = sat_bump(slot_count[base+hit_way]);
        r.flow_count = slot_count[base+hit_way];
        hits++;
      end else if (free_way >= 0) begin
        slot_used[base+free_way]  = 1'b1;
        slot_flow[base+free_way]  = p;
        slot_count[base+free_way] = COUNT_W'(1);
        r.flow_count   = COUNT_W'(1);
        r.new_flow     = 1'b1;
        flows_inserted = sat_bump(flows_inserted);
        inserts++;
      end else begin
        r.table_full = 1'b1;
        rejects++;
      end
      packets_seen    = sat_bump(packets_seen);
      r.total_packets = packets_seen;
      r.total_flows   = flows_inserted;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      mismatches++;
      $display("[%0t] result %0d: %s expected %h got %h", $time, results_checked, what,
               want, got);
    endtask

    task check_result(logic [95:0] data, logic [1:0] user);
      flow_result_t r;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", '0, data[31:0]);
      end else begin
        r = expected_results.pop_front();
        if (data[31:0] !== r.flow_count) report_mismatch("flow_count", r.flow_count, data[31:0]);
        if (data[63:32] !== r.total_packets)
          report_mismatch("total_packets", r.total_packets, data[63:32]);
        if (data[95:64] !== r.total_flows)
          report_mismatch("total_flows", r.total_flows, data[95:64]);
        if (user[0] !== r.new_flow)
          report_mismatch("new_flow", COUNT_W'(r.new_flow), COUNT_W'(user[0]));
        if (user[1] !== r.table_full)
          report_mismatch("table_full", COUNT_W'(r.table_full), COUNT_W'(user[1]));
      end
      results_checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  flow_table_model sb = new();
  bit              calm = 1'b0;
  int unsigned     idle_cycles = 0;
  int unsigned     hot_set[8];
  packet_t         known_flows[$];

  flow_packet_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    packet_t p;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      p.src_addr = s_axis_tdata[31:0];
      p.dst_addr = s_axis_tdata[63:32];
      p.sport    = s_axis_tdata[79:64];
      p.dport    = s_axis_tdata[95:80];
      sb.note_packet(p);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts until the calm tail
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  function automatic packet_t make_packet(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                          logic [15:0] dp);
    packet_t p;
    p.src_addr = sa;
    p.dst_addr = da;
    p.sport    = sp;
    p.dport    = dp;
    return p;
  endfunction

  // pick random addresses and ports, then solve the destination port for the wanted set
  function automatic packet_t packet_in_set(int unsigned set_idx);
    packet_t           p;
    logic [HASH_W-1:0] fold;
    p.src_addr = $urandom();
    p.dst_addr = $urandom();
    p.sport    = $urandom_range(0, 65535);
    fold = HASH_W'($urandom_range(0, 65536 / SETS - 1) * SETS + set_idx);
    p.dport = fold ^ p.src_addr[31:16] ^ p.src_addr[15:0] ^ p.dst_addr[31:16] ^
              p.dst_addr[15:0] ^ p.sport;
    return p;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_packet(packet_t p);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {p.dport, p.sport, p.dst_addr, p.src_addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic hold_off(int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    packet_t     p;
    packet_t     flow_a;
    packet_t     flow_b;
    int unsigned i;
    int unsigned pick;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    foreach (hot_set[k]) hot_set[k] = $urandom_range(0, SETS - 1);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all-zero and all-one keys both land in set 0; fill it, overflow it, hit inside it
    send_packet(make_packet('0, '0, '0, '0));
    send_packet(make_packet('0, '0, '0, '0));
    send_packet(make_packet('1, '1, '1, '1));
    send_packet(make_packet('1, '1, '1, '1));
    send_packet(packet_in_set(0));
    send_packet(packet_in_set(0));
    p = packet_in_set(0);
    send_packet(p);
    send_packet(p);
    send_packet(make_packet('0, '0, '0, '0));
    send_packet(make_packet('1, '1, '1, '1));
    send_packet(make_packet('1, '0, '0, '0));
    send_packet(make_packet('0, '1, '0, '0));
    send_packet(make_packet('0, '0, '1, '0));
    send_packet(make_packet('0, '0, '0, '1));
    flow_a = packet_in_set(SETS - 1);
    flow_b = packet_in_set(SETS - 1);
    send_packet(flow_a);
    send_packet(flow_a);
    send_packet(flow_a);
    send_packet(flow_b);
    send_packet(flow_a);
    send_packet(flow_b);

    wait_drained();

    for (i = 0; i < RANDOM_PKTS; i++) begin
      if (i == RANDOM_PKTS / 2) wait_drained();
      if (i == RANDOM_PKTS - CALM_PKTS) calm = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 12));
      pick = $urandom_range(0, 99);
      if (pick < 40 && known_flows.size() != 0) begin
        p = known_flows[$urandom_range(0, known_flows.size() - 1)];
      end else if (pick < 70) begin
        p = packet_in_set(hot_set[$urandom_range(0, 7)]);
      end else begin
        p = make_packet(pick_word(), pick_word(), pick_half(), pick_half());
      end
      if (pick >= 40) begin
        known_flows.push_back(p);
        if (known_flows.size() > 64) void'(known_flows.pop_front());
      end
      send_packet(p);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d packets: %0d hits, %0d new flows, %0d full-set rejects.",
             sb.packets_seen, sb.hits, sb.inserts, sb.rejects);
    $display("Checked %0d results with %0d mismatches.", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fpc_pkg.sv
rtl/fpc_set_index.sv
rtl/fpc_table_ram.sv
rtl/fpc_way_match.sv
rtl/flow_packet_counter.sv
dv/flow_packet_counter_tb.sv
